### hdl/fpsc_pkg.sv
// Shared types and constants for the forbidden pair set check.
// Holds the command codes and the control and status structs that join
// the controller and the datapath. Depends on nothing.
package fpsc_pkg;

  localparam int ID_W  = 10;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ITEM  = 2'd2;

  typedef struct packed {
    logic take_load;
    logic take_clear;
    logic take_item;
    logic walk_issue;
    logic clean_issue;
    logic sweep_write;
    logic cnt_clr;
    logic out_load;
    logic end_set;
  } fpsc_ctl_t;

  typedef struct packed {
    logic in_range;
    logic walk_more;
    logic walk_done;
    logic clean_more;
    logic clean_done;
    logic sweep_done;
    logic out_free;
    logic overflow_seen;
  } fpsc_stat_t;

endpackage

### hdl/fpsc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Used for the pair table, the set list and the membership bitmap.
// Depends on nothing.
module fpsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/fpsc_ctrl.sv
// Controller state machine for the forbidden pair set check.
// Sequences accept, pair table walk, verdict, set cleanup and bitmap sweep.
// Depends on fpsc_pkg for the command codes and control structs.
module fpsc_ctrl
  import fpsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic              last,
  input  fpsc_stat_t        stat,
  output fpsc_ctl_t         ctl
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_WALK    = 6'b000010,
    S_VERDICT = 6'b000100,
    S_CLEAN   = 6'b001000,
    S_SWEEP   = 6'b010000,
    S_SPARE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   last_flag;
  logic   take;

  assign in_stall = (state != S_IDLE);
  assign take     = in_valid && (state == S_IDLE);

  always_comb begin
    ctl            = '0;
    state_next     = state;
    ctl.take_load  = take && (cmd == CMD_LOAD);
    ctl.take_clear = take && (cmd == CMD_CLEAR);
    ctl.take_item  = take && (cmd == CMD_ITEM);
    unique case (state)
      S_IDLE: begin
        if (ctl.take_item) begin
          if (stat.in_range) begin
            state_next = S_WALK;
          end else if (last) begin
            state_next = S_VERDICT;
          end
        end
      end
      S_WALK: begin
        ctl.walk_issue = stat.walk_more;
        if (stat.walk_done) begin
          ctl.cnt_clr = 1'b1;
          state_next  = last_flag ? S_VERDICT : S_IDLE;
        end
      end
      S_VERDICT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = stat.overflow_seen ? S_SWEEP : S_CLEAN;
        end
      end
      S_CLEAN: begin
        ctl.clean_issue = stat.clean_more;
        if (stat.clean_done) begin
          ctl.cnt_clr = 1'b1;
          ctl.end_set = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SWEEP: begin
        ctl.sweep_write = 1'b1;
        if (stat.sweep_done) begin
          ctl.cnt_clr = 1'b1;
          ctl.end_set = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      last_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.take_item) begin
        last_flag <= last;
      end
    end
  end

endmodule

### hdl/fpsc_dp.sv
// Datapath for the forbidden pair set check: pair table, set list, membership
// bitmap, walk pipeline, counters and the output register.
// Depends on fpsc_pkg and fpsc_ram.
module fpsc_dp
  import fpsc_pkg::*;
#(
  parameter int ID_COUNT   = 1024,
  parameter int PAIR_DEPTH = 256,
  parameter int SET_DEPTH  = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  fpsc_ctl_t       ctl,
  output fpsc_stat_t      stat,
  input  logic [ID_W-1:0] first_id,
  input  logic [ID_W-1:0] second_id,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            conflict,
  output logic            overflow
);

  localparam int BM_DEPTH = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
  localparam int BM_AW    = $clog2(BM_DEPTH);
  localparam int PA_W     = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int SL_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int PC_W     = $clog2(PAIR_DEPTH + 1);
  localparam int SC_W     = $clog2(SET_DEPTH + 1);
  localparam int MAXD_A   = (PAIR_DEPTH > SET_DEPTH) ? PAIR_DEPTH : SET_DEPTH;
  localparam int MAXD     = (MAXD_A > BM_DEPTH) ? MAXD_A : BM_DEPTH;
  localparam int CNT_W    = $clog2(MAXD + 1);

  logic [PC_W-1:0]     pair_count;
  logic [SC_W-1:0]     set_count;
  logic [CNT_W-1:0]    cnt;
  logic                conflict_seen;
  logic                overflow_seen;
  logic [ID_W-1:0]     item_id;
  logic                s1v;
  logic                s2v;
  logic                s2_hit;
  logic                clean_v;

  logic                pair_room;
  logic                set_room;
  logic                in_range;
  logic [2*ID_W-1:0]   pair_rdata;
  logic [ID_W-1:0]     pair_first;
  logic [ID_W-1:0]     pair_second;
  logic [ID_W-1:0]     partner;
  logic                hit;
  logic                partner_ok;
  logic [ID_W-1:0]     list_rdata;
  logic                bm_rdata;
  logic                bm_we;
  logic [BM_AW-1:0]    bm_waddr;
  logic                bm_wdata;
  logic                list_we;
  logic                item_mark;

  assign pair_room = pair_count < PC_W'(PAIR_DEPTH);
  assign set_room  = set_count < SC_W'(SET_DEPTH);
  assign in_range  = 32'(first_id) < ID_COUNT;
  assign item_mark = ctl.take_item && in_range;
  assign list_we   = item_mark && set_room;

  assign pair_first  = pair_rdata[2*ID_W-1:ID_W];
  assign pair_second = pair_rdata[ID_W-1:0];
  assign hit         = (pair_first == item_id) || (pair_second == item_id);
  assign partner     = (pair_first == item_id) ? pair_second : pair_first;
  assign partner_ok  = 32'(partner) < ID_COUNT;

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = first_id[BM_AW-1:0];
    bm_wdata = 1'b1;
    priority if (ctl.sweep_write) begin
      bm_we    = 1'b1;
      bm_waddr = cnt[BM_AW-1:0];
      bm_wdata = 1'b0;
    end else if (clean_v) begin
      bm_we    = 1'b1;
      bm_waddr = list_rdata[BM_AW-1:0];
      bm_wdata = 1'b0;
    end else if (item_mark) begin
      bm_we = 1'b1;
    end
  end

  fpsc_ram #(.WIDTH(2 * ID_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (ctl.take_load && pair_room),
    .waddr (pair_count[PA_W-1:0]),
    .wdata ({first_id, second_id}),
    .raddr (cnt[PA_W-1:0]),
    .rdata (pair_rdata)
  );

  fpsc_ram #(.WIDTH(ID_W), .DEPTH(SET_DEPTH)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (set_count[SL_W-1:0]),
    .wdata (first_id),
    .raddr (cnt[SL_W-1:0]),
    .rdata (list_rdata)
  );

  fpsc_ram #(.WIDTH(1), .DEPTH(BM_DEPTH)) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (partner[BM_AW-1:0]),
    .rdata (bm_rdata)
  );

  always_comb begin
    stat.in_range      = in_range;
    stat.walk_more     = cnt < CNT_W'(pair_count);
    stat.walk_done     = !stat.walk_more && !s1v && !s2v;
    stat.clean_more    = cnt < CNT_W'(set_count);
    stat.clean_done    = !stat.clean_more && !clean_v;
    stat.sweep_done    = cnt == CNT_W'(BM_DEPTH - 1);
    stat.out_free      = !out_valid || !out_stall;
    stat.overflow_seen = overflow_seen;
  end

  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      item_id <= first_id;
    end
    if (ctl.out_load) begin
      conflict <= conflict_seen;
      overflow <= overflow_seen;
    end
    s2_hit <= s1v && hit && partner_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count    <= '0;
      set_count     <= '0;
      cnt           <= '0;
      conflict_seen <= 1'b0;
      overflow_seen <= 1'b0;
      s1v           <= 1'b0;
      s2v           <= 1'b0;
      clean_v       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (ctl.take_clear) begin
        pair_count <= '0;
      end else if (ctl.take_load && pair_room) begin
        pair_count <= pair_count + 1'b1;
      end
      if (ctl.end_set) begin
        set_count <= '0;
      end else if (list_we) begin
        set_count <= set_count + 1'b1;
      end
      if (ctl.out_load) begin
        overflow_seen <= 1'b0;
      end else if ((ctl.take_load && !pair_room) || (item_mark && !set_room)) begin
        overflow_seen <= 1'b1;
      end
      if (ctl.out_load) begin
        conflict_seen <= 1'b0;
      end else if (s2v && s2_hit && bm_rdata) begin
        conflict_seen <= 1'b1;
      end
      if (ctl.cnt_clr) begin
        cnt <= '0;
      end else if (ctl.walk_issue || ctl.clean_issue || ctl.sweep_write) begin
        cnt <= cnt + 1'b1;
      end
      s1v     <= ctl.walk_issue;
      s2v     <= s1v;
      clean_v <= ctl.clean_issue;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/forbidden_pair_set_check.sv
// Forbidden pair set check: stores forbidden ID pairs and tells whether a
// set of IDs holds both members of any stored pair.
// Input channel: in_valid and in_stall carry cmd, first_id, second_id and
// last. Command load appends a pair (dropped and flagged as overflow when the
// table is full), clear empties the table, item adds in-range first_id to the set.
// Output channel: out_valid and out_stall carry conflict and overflow, one
// result for each item that has last set.
// Load and clear are taken while idle. An item with first_id below ID_COUNT
// walks the pair table, one entry a cycle through its single read port,
// followed by a registered bitmap lookup of each entry's partner.
// An item with last set then goes to a verdict step, after which the set's
// bitmap bits are cleared one listed item at a time, or the whole bitmap is
// swept when overflow was flagged.
// After reset the block sweeps the membership bitmap with in_stall high.
// A verdict waits in the output register while out_stall is high; the
// block keeps taking items until it has a second verdict to deliver.
module forbidden_pair_set_check
  import fpsc_pkg::*;
#(
  parameter int ID_COUNT   = 1024,
  parameter int PAIR_DEPTH = 256,
  parameter int SET_DEPTH  = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] cmd,
  input  logic [ID_W-1:0]  first_id,
  input  logic [ID_W-1:0]  second_id,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             conflict,
  output logic             overflow
);

  fpsc_ctl_t  ctl;
  fpsc_stat_t stat;

  fpsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .last     (last),
    .stat     (stat),
    .ctl      (ctl)
  );

  fpsc_dp #(
    .ID_COUNT   (ID_COUNT),
    .PAIR_DEPTH (PAIR_DEPTH),
    .SET_DEPTH  (SET_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .first_id  (first_id),
    .second_id (second_id),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .conflict  (conflict),
    .overflow  (overflow)
  );

endmodule

### tb/sv/tb_forbidden_pair_set_check.sv
`timescale 1ns / 1ps
// Self-checking testbench for forbidden_pair_set_check: directed and random
// pair loads, clears and ID sets, predicted verdicts, random idling on both sides.
// Depends on fpsc_pkg and the forbidden_pair_set_check module.
module tb_forbidden_pair_set_check;
  import fpsc_pkg::*;

  localparam int TB_IDS   = 1024;
  localparam int TB_PAIRS = 256;
  localparam int TB_SET   = 64;
  localparam int POOL_N   = 10;
  localparam int ITEM_GOAL = 1000;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  first_id;
    logic [ID_W-1:0]  second_id;
    logic             last;
  } item_t;

  typedef struct {
    logic conflict;
    logic overflow;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CMD_W-1:0] cmd = CMD_NONE;
  logic [ID_W-1:0]  first_id = '0;
  logic [ID_W-1:0]  second_id = '0;
  logic             last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             conflict;
  logic             overflow;

  item_t       cmd_q[$];
  verdict_t    verdict_q[$];
  item_t       cur_item;
  verdict_t    got_v;
  verdict_t    want_v;
  int unsigned sent_cnt = 0;
  int unsigned queued_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  logic [ID_W-1:0] tbl_first [TB_PAIRS];
  logic [ID_W-1:0] tbl_second [TB_PAIRS];
  int unsigned     tbl_count = 0;
  bit              member [TB_IDS];
  logic [ID_W-1:0] roster [TB_SET];
  int unsigned     roster_count = 0;
  bit              hit = 1'b0;
  bit              spill = 1'b0;

  logic [ID_W-1:0] id_pool [POOL_N];

  forbidden_pair_set_check #(
    .ID_COUNT  (TB_IDS),
    .PAIR_DEPTH(TB_PAIRS),
    .SET_DEPTH (TB_SET)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .first_id (first_id),
    .second_id(second_id),
    .last     (last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .conflict (conflict),
    .overflow (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic apply_command(input item_t it);
    verdict_t v;
    int unsigned k;
    case (it.cmd)
      CMD_LOAD: begin
        if (tbl_count < TB_PAIRS) begin
          tbl_first[tbl_count] = it.first_id;
          tbl_second[tbl_count] = it.second_id;
          tbl_count++;
        end else begin
          spill = 1'b1;
        end
      end
      CMD_CLEAR: tbl_count = 0;
      CMD_ITEM: begin
        if (int'(it.first_id) < TB_IDS) begin
          member[it.first_id] = 1'b1;
          if (roster_count < TB_SET) begin
            roster[roster_count] = it.first_id;
            roster_count++;
          end else begin
            spill = 1'b1;
          end
          for (k = 0; k < tbl_count; k++) begin
            if (tbl_first[k] == it.first_id && member[tbl_second[k]]) hit = 1'b1;
            if (tbl_second[k] == it.first_id && member[tbl_first[k]]) hit = 1'b1;
          end
        end
        if (it.last) begin
          v.conflict = hit;
          v.overflow = spill;
          verdict_q = {verdict_q, v};
          if (spill) begin
            for (k = 0; k < TB_IDS; k++) member[k] = 1'b0;
          end else begin
            for (k = 0; k < roster_count; k++) member[roster[k]] = 1'b0;
          end
          roster_count = 0;
          hit = 1'b0;
          spill = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_cmd(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] a,
                         input logic [ID_W-1:0] b, input logic l);
    item_t it;
    it.cmd = c;
    it.first_id = a;
    it.second_id = b;
    it.last = l;
    cmd_q = {cmd_q, it};
    queued_cnt++;
    if (c != CMD_NONE) sent_cnt++;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    return id_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  task automatic queue_noise();
    case ($urandom_range(0, 2))
      0: add_cmd(CMD_NONE, ID_W'($urandom), ID_W'($urandom), 1'($urandom_range(0, 1)));
      1: add_cmd(CMD_ITEM, ID_W'($urandom), ID_W'($urandom), 1'b0);
      default: add_cmd(CMD_LOAD, pick_id(), ID_W'($urandom), 1'($urandom_range(0, 1)));
    endcase
  endtask

  task automatic queue_pairs(input int unsigned n);
    int unsigned j;
    for (j = 0; j < n; j++) begin
      add_cmd(CMD_LOAD, pick_id(), pick_id(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic queue_set(input int unsigned len);
    int unsigned j;
    for (j = 0; j < len; j++) begin
      if ($urandom_range(0, 9) == 0) queue_noise();
      add_cmd(CMD_ITEM, pick_id(), ID_W'($urandom), j == len - 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(cur_item);
        taken_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_item = cmd_q.pop_front();
          cmd <= cur_item.cmd;
          first_id <= cur_item.first_id;
          second_id <= cur_item.second_id;
          last <= cur_item.last;
          in_valid <= 1'b1;
          gap_left <= pick_gap(in_burst);
          if ($urandom_range(0, 49) == 0) in_burst <= !in_burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_v.conflict = conflict;
        got_v.overflow = overflow;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict conflict=%0b overflow=%0b with none pending",
                                    got_v.conflict, got_v.overflow));
        end else begin
          want_v = verdict_q.pop_front();
          if (got_v.conflict !== want_v.conflict)
            report_mismatch($sformatf("conflict got %0b want %0b",
                                      got_v.conflict, want_v.conflict));
          if (got_v.overflow !== want_v.overflow)
            report_mismatch($sformatf("overflow got %0b want %0b",
                                      got_v.overflow, want_v.overflow));
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (!out_burst && $urandom_range(0, 3) == 0)
          stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                    : $urandom_range(1, 3);
      end
      if ($urandom_range(0, 199) == 0) out_burst <= !out_burst;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned j;
    for (j = 0; j < TB_IDS; j++) member[j] = 1'b0;

    // Directed part: empty table, extreme IDs, a self pair, repeated IDs,
    // the unused command, and a clear between sets.
    add_cmd(CMD_ITEM, 10'd5, 10'd0, 1'b1);
    add_cmd(CMD_LOAD, 10'd0, 10'd1023, 1'b1);
    add_cmd(CMD_LOAD, 10'd7, 10'd7, 1'b0);
    add_cmd(CMD_LOAD, 10'd1023, 10'd0, 1'b0);
    add_cmd(CMD_ITEM, 10'd0, 10'd1023, 1'b0);
    add_cmd(CMD_ITEM, 10'd1023, 10'd0, 1'b1);
    add_cmd(CMD_ITEM, 10'd7, 10'd0, 1'b1);
    add_cmd(CMD_ITEM, 10'd0, 10'd0, 1'b0);
    add_cmd(CMD_ITEM, 10'd0, 10'd0, 1'b0);
    add_cmd(CMD_ITEM, 10'd512, 10'd1023, 1'b1);
    add_cmd(CMD_NONE, 10'd1023, 10'd1023, 1'b1);
    add_cmd(CMD_CLEAR, 10'd1023, 10'd1023, 1'b1);
    add_cmd(CMD_ITEM, 10'd0, 10'd0, 1'b0);
    add_cmd(CMD_ITEM, 10'd1023, 10'd0, 1'b1);
    add_cmd(CMD_LOAD, 10'd1023, 10'd1023, 1'b0);
    add_cmd(CMD_ITEM, 10'd1023, 10'd1023, 1'b1);
    add_cmd(CMD_CLEAR, 10'd0, 10'd0, 1'b0);

    // Random part: each phase draws a small ID pool so that pairs and sets
    // overlap often, with an occasional full table or an overlong set.
    phase = 0;
    while (sent_cnt < ITEM_GOAL) begin
      for (j = 0; j < POOL_N; j++) begin
        if ($urandom_range(0, 3) == 0)
          id_pool[j] = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        else
          id_pool[j] = ID_W'($urandom_range(0, TB_IDS - 1));
      end
      if ($urandom_range(0, 1) == 0)
        add_cmd(CMD_CLEAR, ID_W'($urandom), ID_W'($urandom), 1'($urandom_range(0, 1)));
      if (phase == 2 || $urandom_range(0, 29) == 0)
        queue_pairs($urandom_range(TB_PAIRS + 1, TB_PAIRS + 6));
      else
        queue_pairs($urandom_range(0, 10));
      repeat ($urandom_range(1, 5)) begin
        if (phase == 4 || $urandom_range(0, 24) == 0)
          queue_set($urandom_range(TB_SET, TB_SET + 4));
        else
          queue_set($urandom_range(1, 6));
      end
      phase++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (taken_cnt != queued_cnt) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (verdict_q.size() != 0) report_mismatch("verdicts still pending at end of run");

    if (mismatch_cnt == 0) begin
      $display("forbidden_pair_set_check test passed");
    end else begin
      $display("forbidden_pair_set_check test failed");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("forbidden_pair_set_check test failed");
    $finish;
  end

endmodule

### sim.f
hdl/fpsc_pkg.sv
hdl/fpsc_ram.sv
hdl/fpsc_ctrl.sv
hdl/fpsc_dp.sv
hdl/forbidden_pair_set_check.sv
tb/sv/tb_forbidden_pair_set_check.sv
